FILE: rtl/ctsb_pkg.sv
// ----------------------------------------------------------------------------
// ctsb_pkg
// Shared types and constants for the Cartesian tree stack builder.
// ----------------------------------------------------------------------------
package ctsb_pkg;

    localparam int IDX_W = 10;
    localparam int VAL_W = 32;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } ctsb_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] node_index;
        logic [IDX_W-1:0] parent_index;
        logic             is_root;
        logic             overflow;
        logic             last_result;
    } ctsb_result_t;

    // classification of one accepted beat, passed from front to back
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             ovf;
        logic             last;
    } ctsb_tag_t;

endpackage

FILE: rtl/cartesian_tree_stack_builder_core.sv
// ----------------------------------------------------------------------------
// cartesian_tree_stack_builder_core
// Minimum Cartesian tree builder over a stream of signed values.
//
// Usage: send one value per beat on the item channel, last set on the final
// value of a sequence. Each beat gets the next index of the sequence. The
// result channel carries parent-write records (node, parent); apply them in
// order, last write wins. After the last beat the root record follows and
// the index restarts at zero. Beats beyond CAPACITY return one overflow
// record and are otherwise dropped. last_result marks the final record of a
// beat; a beat may cause no record at all.
// Timing: the front end takes a beat whenever its two-entry queue has room.
// The stack engine takes each beat through compare, parent and child states
// (an overflow beat through the overflow state instead), adds a compare and,
// unless the stack is then empty, a stack RAM read of the new top per popped
// entry, and ends a sequence in the root state; each entry pops at most once.
// A stalled receiver holds the output register; the engine then waits and
// the queue fills before item_ready drops.
// Reset: empty stack, index zero, no record pending; the stack RAM needs no
// clearing.
// ----------------------------------------------------------------------------
module cartesian_tree_stack_builder_core
    import ctsb_pkg::*;
#(
    parameter int CAPACITY    = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  ctsb_item_t   item_data,
    output logic         result_valid,
    input  logic         result_ready,
    output ctsb_result_t result_data
);

    logic                   q_valid;
    logic                   q_ready;
    logic [VALUE_WIDTH-1:0] q_key;
    ctsb_tag_t              q_tag;

    ctsb_front #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item_data  (item_data),
        .q_valid    (q_valid),
        .q_ready    (q_ready),
        .q_key      (q_key),
        .q_tag      (q_tag)
    );

    ctsb_back #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_key        (q_key),
        .q_tag        (q_tag),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule

FILE: rtl/ctsb_ram.sv
// ----------------------------------------------------------------------------
// ctsb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ctsb_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ctsb_front.sv
// ----------------------------------------------------------------------------
// ctsb_front
// Accepts input beats, assigns sequence indices, flags overflow and buffers
// the classified beats in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module ctsb_front
    import ctsb_pkg::*;
#(
    parameter int CAPACITY    = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  ctsb_item_t             item_data,
    output logic                   q_valid,
    input  logic                   q_ready,
    output logic [VALUE_WIDTH-1:0] q_key,
    output ctsb_tag_t              q_tag
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_L = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic [VALUE_WIDTH-1:0] key_mem [2];
    ctsb_tag_t              tag_mem [2];
    logic                   wr_ptr_reg;
    logic                   rd_ptr_reg;
    logic [1:0]             fill_reg;
    logic                   push;
    logic                   pop;
    logic [63:0]            value_ext;
    logic [VALUE_WIDTH-1:0] key;
    ctsb_tag_t              tag;

    assign item_ready = (fill_reg != 2'd2);
    assign push       = item_valid && item_ready;
    assign pop        = q_valid && q_ready;
    assign q_valid    = (fill_reg != 2'd0);
    assign q_key      = key_mem[rd_ptr_reg];
    assign q_tag      = tag_mem[rd_ptr_reg];

    // map signed value to an unsigned key with the same order
    assign value_ext = {{(64-VAL_W){item_data.value[VAL_W-1]}}, item_data.value};
    assign key       = value_ext[VALUE_WIDTH-1:0] ^ {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    always_comb
    begin
        tag.idx  = IDX_W'(cnt_reg);
        tag.ovf  = (cnt_reg >= CAP_L);
        tag.last = item_data.last;
        if (item_data.last)
        begin
            cnt_next = '0;
        end
        else if (tag.ovf)
        begin
            cnt_next = cnt_reg;
        end
        else
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            key_mem[wr_ptr_reg] <= key;
            tag_mem[wr_ptr_reg] <= tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                cnt_reg    <= cnt_next;
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/ctsb_back.sv
// ----------------------------------------------------------------------------
// ctsb_back
// Monotone stack engine: pops greater entries, emits parent records, the root
// record and overflow records, and holds results in an output register.
// ----------------------------------------------------------------------------
module ctsb_back
    import ctsb_pkg::*;
#(
    parameter int CAPACITY    = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  logic [VALUE_WIDTH-1:0] q_key,
    input  ctsb_tag_t              q_tag,
    output logic                   result_valid,
    input  logic                   result_ready,
    output ctsb_result_t           result_data
);

    localparam int DEP_W = $clog2(CAPACITY + 1);
    localparam int AW    = $clog2(CAPACITY);
    localparam int ENT_W = VALUE_WIDTH + IDX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMP   = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_PAR   = 3'd3;
    localparam logic [2:0] S_CHILD = 3'd4;
    localparam logic [2:0] S_ROOT  = 3'd5;
    localparam logic [2:0] S_OVF   = 3'd6;

    logic [2:0]             state_reg,    state_next;
    logic [DEP_W-1:0]       depth_reg,    depth_next;
    logic [VALUE_WIDTH-1:0] work_key_reg, work_key_next;
    ctsb_tag_t              work_tag_reg, work_tag_next;
    logic                   popped_reg,   popped_next;
    logic [IDX_W-1:0]       deepest_reg,  deepest_next;
    logic [VALUE_WIDTH-1:0] top_key_reg,  top_key_next;
    logic [IDX_W-1:0]       top_idx_reg,  top_idx_next;
    logic [IDX_W-1:0]       bottom_reg,   bottom_next;
    logic                   out_valid_reg;
    ctsb_result_t           out_reg;

    logic                   can_emit;
    logic                   emit;
    ctsb_result_t           rec;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [ENT_W-1:0]       ram_wdata;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [ENT_W-1:0]       ram_rdata;
    logic [DEP_W-1:0]       depth_m1;
    logic [DEP_W-1:0]       depth_m2;

    ctsb_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign can_emit     = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;
    assign depth_m1     = depth_reg - DEP_W'(1);
    assign depth_m2     = depth_reg - DEP_W'(2);

    always_comb
    begin
        state_next    = state_reg;
        depth_next    = depth_reg;
        work_key_next = work_key_reg;
        work_tag_next = work_tag_reg;
        popped_next   = popped_reg;
        deepest_next  = deepest_reg;
        top_key_next  = top_key_reg;
        top_idx_next  = top_idx_reg;
        bottom_next   = bottom_reg;
        q_ready       = 1'b0;
        emit          = 1'b0;
        rec           = '0;
        ram_we        = 1'b0;
        ram_waddr     = depth_m1[AW-1:0];
        ram_wdata     = {top_key_reg, top_idx_reg};
        ram_re        = 1'b0;
        ram_raddr     = depth_m2[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    work_key_next = q_key;
                    work_tag_next = q_tag;
                    popped_next   = 1'b0;
                    state_next    = q_tag.ovf ? S_OVF : S_CMP;
                end
            end
            S_CMP:
            begin
                if ((depth_reg != '0) && (top_key_reg > work_key_reg))
                begin
                    deepest_next = top_idx_reg;
                    popped_next  = 1'b1;
                    depth_next   = depth_m1;
                    if (depth_reg > DEP_W'(1))
                    begin
                        ram_re     = 1'b1;
                        state_next = S_LOAD;
                    end
                end
                else
                begin
                    state_next = S_PAR;
                end
            end
            S_LOAD:
            begin
                top_key_next = ram_rdata[ENT_W-1:IDX_W];
                top_idx_next = ram_rdata[IDX_W-1:0];
                state_next   = S_CMP;
            end
            S_PAR:
            begin
                if (depth_reg == '0)
                begin
                    state_next = S_CHILD;
                end
                else if (can_emit)
                begin
                    emit             = 1'b1;
                    rec.node_index   = work_tag_reg.idx;
                    rec.parent_index = top_idx_reg;
                    rec.last_result  = !popped_reg && !work_tag_reg.last;
                    state_next       = S_CHILD;
                end
            end
            S_CHILD:
            begin
                if (!popped_reg || can_emit)
                begin
                    if (popped_reg)
                    begin
                        emit             = 1'b1;
                        rec.node_index   = deepest_reg;
                        rec.parent_index = work_tag_reg.idx;
                        rec.last_result  = !work_tag_reg.last;
                    end
                    // push: spill the old top, the new node becomes top
                    if (depth_reg != '0)
                    begin
                        ram_we = 1'b1;
                    end
                    else
                    begin
                        bottom_next = work_tag_reg.idx;
                    end
                    top_key_next = work_key_reg;
                    top_idx_next = work_tag_reg.idx;
                    depth_next   = depth_reg + DEP_W'(1);
                    popped_next  = 1'b0;
                    state_next   = work_tag_reg.last ? S_ROOT : S_IDLE;
                end
            end
            S_ROOT:
            begin
                if (depth_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else if (can_emit)
                begin
                    emit            = 1'b1;
                    rec.node_index  = bottom_reg;
                    rec.is_root     = 1'b1;
                    rec.last_result = 1'b1;
                    depth_next      = '0;
                    state_next      = S_IDLE;
                end
            end
            S_OVF:
            begin
                if (can_emit)
                begin
                    emit            = 1'b1;
                    rec.overflow    = 1'b1;
                    rec.last_result = !(work_tag_reg.last && (depth_reg != '0));
                    state_next      = work_tag_reg.last ? S_ROOT : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        work_key_reg <= work_key_next;
        work_tag_reg <= work_tag_next;
        deepest_reg  <= deepest_next;
        top_key_reg  <= top_key_next;
        top_idx_reg  <= top_idx_next;
        bottom_reg   <= bottom_next;
        if (emit)
        begin
            out_reg <= rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            popped_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            depth_reg  <= depth_next;
            popped_reg <= popped_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
